// ----- rtl/eeg_pkg.sv -----
// Shared types, constants and microcode word layout for the GF(23) ElGamal encryptor.
package eeg_pkg;

  localparam int unsigned COORD_W     = 5;
  localparam int unsigned SCALAR_BITS = 5;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned UPC_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned NUM_PTS     = 28;
  localparam int unsigned INV_DEPTH   = 23;

  typedef logic [COORD_W-1:0] coord_t;

  localparam coord_t SYM_LAST = 5'd27;

  // inverse mod 23; entry 0 maps to 0
  localparam coord_t INV_TAB [INV_DEPTH] = '{
    5'd0, 5'd1, 5'd12, 5'd8, 5'd6, 5'd14, 5'd4, 5'd10, 5'd3, 5'd18, 5'd7, 5'd21,
    5'd2, 5'd16, 5'd5, 5'd20, 5'd13, 5'd19, 5'd9, 5'd17, 5'd15, 5'd11, 5'd22
  };

  localparam coord_t PT_X [NUM_PTS] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd3, 5'd3, 5'd4, 5'd5, 5'd5, 5'd6, 5'd6, 5'd7, 5'd7,
    5'd9, 5'd9, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd17, 5'd17, 5'd18, 5'd18,
    5'd19, 5'd19
  };

  localparam coord_t PT_Y [NUM_PTS] = '{
    5'd0, 5'd1, 5'd22, 5'd7, 5'd16, 5'd10, 5'd13, 5'd0, 5'd4, 5'd19, 5'd4, 5'd19, 5'd11,
    5'd12, 5'd7, 5'd16, 5'd3, 5'd20, 5'd4, 5'd19, 5'd7, 5'd16, 5'd3, 5'd20, 5'd3, 5'd20,
    5'd5, 5'd18
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_X  = 3'd0,
    CFG_BASE_Y  = 3'd1,
    CFG_PUB_X   = 3'd2,
    CFG_PUB_Y   = 3'd3,
    CFG_CURVE_A = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    C_NEXT  = 3'd0,
    C_JUMP  = 3'd1,
    C_LOOP  = 3'd2,
    C_FETCH = 3'd3,
    C_EMIT  = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    OPA_ACC = 2'd0,
    OPA_DBL = 2'd1,
    OPA_MSG = 2'd2
  } opa_e;

  typedef enum logic {
    OPB_DBL    = 1'b0,
    OPB_SHARED = 1'b1
  } opb_e;

  typedef enum logic [1:0] {
    DST_ACC  = 2'd0,
    DST_DBL  = 2'd1,
    DST_CIPH = 2'd2
  } dst_e;

  typedef enum logic [1:0] {
    INIT_NONE = 2'd0,
    INIT_PUB  = 2'd1,
    INIT_BASE = 2'd2
  } init_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_SHARED = 2'd1,
    ST_EPHEM  = 2'd2
  } store_e;

  typedef struct packed {
    cond_e            cond;
    logic             add;
    logic             gated;
    opa_e             opa;
    opb_e             opb;
    dst_e             dst;
    init_e            init;
    store_e           store;
    logic [UPC_W-1:0] target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    logic   start;
    opa_e   opa;
    opb_e   opb;
    dst_e   dst;
    init_e  init;
    store_e store;
    logic   fetch;
    logic   emit;
  } cmd_t;

  // datapath -> sequencer
  typedef struct packed {
    logic                   in_valid;
    logic                   in_new;
    logic [SCALAR_BITS-1:0] nonce;
    logic                   add_done;
    logic                   out_free;
  } stat_t;

endpackage

// ----- rtl/eeg_if.sv -----
// Request channel interfaces: input items, result items and register writes.
interface eeg_in_if import eeg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t symbol;
  coord_t nonce;
  logic   new_message;

  modport source (output valid, output symbol, output nonce, output new_message, input ready);
  modport sink   (input valid, input symbol, input nonce, input new_message, output ready);
endinterface

interface eeg_out_if import eeg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t cipher_x;
  coord_t cipher_y;
  coord_t mask_x;
  coord_t mask_y;

  modport source (output valid, output cipher_x, output cipher_y, output mask_x,
                  output mask_y, input ready);
  modport sink   (input valid, input cipher_x, input cipher_y, input mask_x,
                  input mask_y, output ready);
endinterface

interface eeg_cfg_if import eeg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coord_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/eeg_padd.sv -----
// Multi-cycle GF(23) point adder: at most one multiply per stage, result after eight stages.
module eeg_padd import eeg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  coord_t a_i,
  input  coord_t x1_i,
  input  coord_t y1_i,
  input  coord_t x2_i,
  input  coord_t y2_i,
  output logic   done_o,
  output coord_t x_o,
  output coord_t y_o
);

  typedef enum logic [8:0] {
    PS_IDLE = 9'b000000001,
    PS_PREP = 9'b000000010,
    PS_NUM  = 9'b000000100,
    PS_MUL  = 9'b000001000,
    PS_K    = 9'b000010000,
    PS_SQ   = 9'b000100000,
    PS_X3   = 9'b001000000,
    PS_KD   = 9'b010000000,
    PS_Y3   = 9'b100000000
  } padd_st_e;

  // reduce a value below 92
  function automatic coord_t red_small(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd69) begin
      t = t - 7'd69;
    end else if (t >= 7'd46) begin
      t = t - 7'd46;
    end else if (t >= 7'd23) begin
      t = t - 7'd23;
    end
    return t[COORD_W-1:0];
  endfunction

  // reciprocal estimate 2849/2^16 is low by at most one, so one correction
  function automatic coord_t mod23(input logic [11:0] v);
    logic [23:0] m;
    logic [7:0]  q;
    logic [11:0] r;
    m = {12'd0, v} * 24'd2849;
    q = m[23:16];
    r = v - ({4'd0, q} * 12'd23);
    if (r >= 12'd23) begin
      r = r - 12'd23;
    end
    return r[COORD_W-1:0];
  endfunction

  padd_st_e    st_q, st_d;
  logic        done_q;
  coord_t      x1_q, y1_q, x2_q, y2_q, a_q;
  coord_t      num_q, den_q, inv_q, k_q, x3_q, d_q, x_q, y_q;
  logic [9:0]  sq_q;
  logic [8:0]  prod_q;
  logic        eqx, eqy, z1, z2;
  coord_t      den_c, chord_c, tan_c, x3_c, d_c, y3_c;

  assign eqx = (x1_q == x2_q);
  assign eqy = (y1_q == y2_q);
  assign z1  = (x1_q == '0) && (y1_q == '0);
  assign z2  = (x2_q == '0) && (y2_q == '0);

  assign den_c   = eqx ? red_small({1'b0, y1_q, 1'b0})
                       : red_small({2'b0, x2_q} + 7'd46 - {2'b0, x1_q});
  assign chord_c = red_small({2'b0, y2_q} + 7'd46 - {2'b0, y1_q});
  assign tan_c   = mod23({2'b0, sq_q} + {1'b0, sq_q, 1'b0} + {7'b0, a_q});
  assign x3_c    = mod23({3'b0, prod_q} + 12'd69 - {7'b0, x1_q} - {7'b0, x2_q});
  assign d_c     = red_small({2'b0, x1_q} + 7'd23 - {2'b0, x3_c});
  assign y3_c    = mod23({3'b0, prod_q} + 12'd46 - {7'b0, y1_q});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      PS_IDLE: if (start_i) st_d = PS_PREP;
      PS_PREP: st_d = PS_NUM;
      PS_NUM:  st_d = PS_MUL;
      PS_MUL:  st_d = PS_K;
      PS_K:    st_d = PS_SQ;
      PS_SQ:   st_d = PS_X3;
      PS_X3:   st_d = PS_KD;
      PS_KD:   st_d = PS_Y3;
      PS_Y3:   st_d = PS_IDLE;
      default: st_d = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= PS_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == PS_Y3);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      PS_IDLE: begin
        if (start_i) begin
          x1_q <= x1_i;
          y1_q <= y1_i;
          x2_q <= x2_i;
          y2_q <= y2_i;
          a_q  <= a_i;
        end
      end
      PS_PREP: begin
        den_q <= den_c;
        num_q <= chord_c;
        sq_q  <= {5'b0, x1_q} * {5'b0, x1_q};
      end
      PS_NUM: begin
        inv_q <= INV_TAB[den_q];
        if (eqx) begin
          num_q <= tan_c;
        end
      end
      PS_MUL: prod_q <= {4'b0, num_q} * {4'b0, inv_q};
      PS_K:   k_q    <= mod23({3'b0, prod_q});
      PS_SQ:  prod_q <= {4'b0, k_q} * {4'b0, k_q};
      PS_X3: begin
        x3_q <= x3_c;
        d_q  <= d_c;
      end
      PS_KD:  prod_q <= {4'b0, k_q} * {4'b0, d_q};
      PS_Y3: begin
        if (z1) begin
          x_q <= x2_q;
          y_q <= y2_q;
        end else if (z2) begin
          x_q <= x1_q;
          y_q <= y1_q;
        end else if (eqx && !eqy) begin
          x_q <= '0;
          y_q <= '0;
        end else begin
          x_q <= x3_q;
          y_q <= y3_c;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ----- rtl/eeg_useq.sv -----
// Microcode sequencer: program ROM, step counter, scalar bit counter and jump logic.
module eeg_useq import eeg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [UPC_W-1:0] S_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] S_INIT_K = 4'd1;
  localparam logic [UPC_W-1:0] S_ADD_K  = 4'd2;
  localparam logic [UPC_W-1:0] S_DBL_K  = 4'd3;
  localparam logic [UPC_W-1:0] S_INIT_G = 4'd4;
  localparam logic [UPC_W-1:0] S_ADD_G  = 4'd5;
  localparam logic [UPC_W-1:0] S_DBL_G  = 4'd6;
  localparam logic [UPC_W-1:0] S_STORE  = 4'd7;
  localparam logic [UPC_W-1:0] S_ENC    = 4'd8;
  localparam logic [UPC_W-1:0] S_EMIT   = 4'd9;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCALAR_BITS - 1);

  function automatic uword_t rom(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '{cond: C_NEXT, add: 1'b0, gated: 1'b0, opa: OPA_ACC, opb: OPB_DBL,
          dst: DST_ACC, init: INIT_NONE, store: ST_NONE, target: S_FETCH};
    unique case (a)
      S_FETCH: begin
        w.cond   = C_FETCH;
        w.target = S_ENC;
      end
      S_INIT_K: w.init = INIT_PUB;
      S_ADD_K: begin
        w.add   = 1'b1;
        w.gated = 1'b1;
      end
      S_DBL_K: begin
        w.add    = 1'b1;
        w.opa    = OPA_DBL;
        w.dst    = DST_DBL;
        w.cond   = C_LOOP;
        w.target = S_ADD_K;
      end
      S_INIT_G: begin
        w.store = ST_SHARED;
        w.init  = INIT_BASE;
      end
      S_ADD_G: begin
        w.add   = 1'b1;
        w.gated = 1'b1;
      end
      S_DBL_G: begin
        w.add    = 1'b1;
        w.opa    = OPA_DBL;
        w.dst    = DST_DBL;
        w.cond   = C_LOOP;
        w.target = S_ADD_G;
      end
      S_STORE: w.store = ST_EPHEM;
      S_ENC: begin
        w.add = 1'b1;
        w.opa = OPA_MSG;
        w.opb = OPB_SHARED;
        w.dst = DST_CIPH;
      end
      S_EMIT: begin
        w.cond   = C_EMIT;
        w.target = S_FETCH;
      end
      default: w.cond = C_JUMP;
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             busy_q, busy_d;
  logic             need_add, start, adv;
  uword_t           w;

  assign w        = rom(upc_q);
  // gated adds are skipped when the current scalar bit is clear
  assign need_add = w.add && (!w.gated || stat_i.nonce[idx_q]);

  always_comb begin
    upc_d  = upc_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    start  = 1'b0;
    adv    = 1'b0;
    if (need_add) begin
      if (!busy_q) begin
        start  = 1'b1;
        busy_d = 1'b1;
      end else if (stat_i.add_done) begin
        busy_d = 1'b0;
        adv    = 1'b1;
      end
    end else begin
      adv = 1'b1;
    end
    if (w.init != INIT_NONE) begin
      idx_d = '0;
    end
    if (adv) begin
      unique case (w.cond)
        C_NEXT: upc_d = upc_q + 1'b1;
        C_JUMP: upc_d = w.target;
        C_LOOP: begin
          if (idx_q == IDX_LAST) begin
            upc_d = upc_q + 1'b1;
          end else begin
            upc_d = w.target;
            idx_d = idx_q + 1'b1;
          end
        end
        C_FETCH: begin
          if (stat_i.in_valid) begin
            upc_d = stat_i.in_new ? upc_q + 1'b1 : w.target;
          end
        end
        C_EMIT: if (stat_i.out_free) upc_d = w.target;
        default: upc_d = S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= S_FETCH;
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_comb begin
    cmd_o.start = start;
    cmd_o.opa   = w.opa;
    cmd_o.opb   = w.opb;
    cmd_o.dst   = w.dst;
    cmd_o.init  = w.init;
    cmd_o.store = w.store;
    cmd_o.fetch = (w.cond == C_FETCH);
    cmd_o.emit  = (w.cond == C_EMIT);
  end

endmodule

// ----- rtl/ecc_elgamal_encrypt_gf23.sv -----
// Top level: register file, point registers, output stage, sequencer and point adder.
//
//  channel  | dir | fields                                  | handshake
//  ---------+-----+-----------------------------------------+-------------
//  in_req   | in  | symbol, nonce, new_message              | valid/ready
//  out_req  | out | cipher_x, cipher_y, mask_x, mask_y      | valid/ready
//  cfg_req  | in  | index (0 base_x .. 4 curve_a), data     | valid/ready
//
// One item at a time. Every point add goes through the shared adder.
// A plain symbol needs one add. A new message adds the 10 doublings plus one add
// per set nonce bit, for both scalar multiplies.
// The result sits in an output register; the next request is taken while it waits,
// and the sequencer stalls on emit only if that register is still full.
// Reset clears control, registers to their reset values and r*K, r*G to (0,0).
module ecc_elgamal_encrypt_gf23 import eeg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  eeg_in_if.sink     in_req,
  eeg_out_if.source  out_req,
  eeg_cfg_if.sink    cfg_req
);

  coord_t base_x_q, base_y_q, pub_x_q, pub_y_q, curve_a_q;
  coord_t shared_x_q, shared_y_q, ephem_x_q, ephem_y_q;
  coord_t acc_x_q, acc_y_q, dbl_x_q, dbl_y_q, ciph_x_q, ciph_y_q;
  coord_t sym_q;
  logic [SCALAR_BITS-1:0] nonce_q;
  logic   out_valid_q;
  coord_t out_cx_q, out_cy_q, out_mx_q, out_my_q;

  cmd_t   cmd;
  stat_t  stat;
  logic   take, out_free, emit_fire, add_done;
  coord_t ax, ay, bx, by, rx, ry;

  assign take      = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_q || out_req.ready;
  assign emit_fire = cmd.emit && out_free;

  assign in_req.ready  = cmd.fetch;
  assign cfg_req.ready = 1'b1;

  always_comb begin
    stat.in_valid = in_req.valid;
    stat.in_new   = in_req.new_message;
    stat.nonce    = nonce_q;
    stat.add_done = add_done;
    stat.out_free = out_free;
  end

  eeg_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  always_comb begin
    case (cmd.opa)
      OPA_DBL: begin
        ax = dbl_x_q;
        ay = dbl_y_q;
      end
      OPA_MSG: begin
        ax = PT_X[sym_q];
        ay = PT_Y[sym_q];
      end
      default: begin
        ax = acc_x_q;
        ay = acc_y_q;
      end
    endcase
    if (cmd.opb == OPB_SHARED) begin
      bx = shared_x_q;
      by = shared_y_q;
    end else begin
      bx = dbl_x_q;
      by = dbl_y_q;
    end
  end

  eeg_padd u_padd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.start),
    .a_i     (curve_a_q),
    .x1_i    (ax),
    .y1_i    (ay),
    .x2_i    (bx),
    .y2_i    (by),
    .done_o  (add_done),
    .x_o     (rx),
    .y_o     (ry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q    <= '0;
      base_y_q    <= '0;
      pub_x_q     <= '0;
      pub_y_q     <= '0;
      curve_a_q   <= 5'd1;
      shared_x_q  <= '0;
      shared_y_q  <= '0;
      ephem_x_q   <= '0;
      ephem_y_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_req.valid) begin
        case (cfg_req.index)
          CFG_BASE_X:  base_x_q  <= cfg_req.data;
          CFG_BASE_Y:  base_y_q  <= cfg_req.data;
          CFG_PUB_X:   pub_x_q   <= cfg_req.data;
          CFG_PUB_Y:   pub_y_q   <= cfg_req.data;
          CFG_CURVE_A: curve_a_q <= cfg_req.data;
          default: ;
        endcase
      end
      case (cmd.store)
        ST_SHARED: begin
          shared_x_q <= acc_x_q;
          shared_y_q <= acc_y_q;
        end
        ST_EPHEM: begin
          ephem_x_q <= acc_x_q;
          ephem_y_q <= acc_y_q;
        end
        default: ;
      endcase
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sym_q   <= (in_req.symbol > SYM_LAST) ? SYM_LAST : in_req.symbol;
      nonce_q <= in_req.nonce;
    end
    case (cmd.init)
      INIT_PUB: begin
        acc_x_q <= '0;
        acc_y_q <= '0;
        dbl_x_q <= pub_x_q;
        dbl_y_q <= pub_y_q;
      end
      INIT_BASE: begin
        acc_x_q <= '0;
        acc_y_q <= '0;
        dbl_x_q <= base_x_q;
        dbl_y_q <= base_y_q;
      end
      default: ;
    endcase
    if (add_done) begin
      case (cmd.dst)
        DST_DBL: begin
          dbl_x_q <= rx;
          dbl_y_q <= ry;
        end
        DST_CIPH: begin
          ciph_x_q <= rx;
          ciph_y_q <= ry;
        end
        default: begin
          acc_x_q <= rx;
          acc_y_q <= ry;
        end
      endcase
    end
    if (emit_fire) begin
      out_cx_q <= ciph_x_q;
      out_cy_q <= ciph_y_q;
      out_mx_q <= ephem_x_q;
      out_my_q <= ephem_y_q;
    end
  end

  assign out_req.valid    = out_valid_q;
  assign out_req.cipher_x = out_cx_q;
  assign out_req.cipher_y = out_cy_q;
  assign out_req.mask_x   = out_mx_q;
  assign out_req.mask_y   = out_my_q;

endmodule
